// ----- design/bpf_pkg.sv -----
`default_nettype none
package bpf_pkg;

  // Command codes carried by the kind field of an input item.
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_MOVE  = 3'd0;
  localparam logic [KIND_W-1:0] K_LINE  = 3'd1;
  localparam logic [KIND_W-1:0] K_QUAD  = 3'd2;
  localparam logic [KIND_W-1:0] K_CUBIC = 3'd3;
  localparam logic [KIND_W-1:0] K_CLOSE = 3'd4;

  // Points per curve register and the running length.
  localparam int EVAL_W = 7;
  localparam logic [EVAL_W-1:0] EVAL_RESET = 7'd16;
  localparam int LEN_W = 32;

endpackage
`default_nettype wire

// ----- design/bpf_isqrt.sv -----
`default_nettype none
module bpf_isqrt #(
  parameter int ROOT_W = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic                       done,
  output logic [ROOT_W:0]            root
);

  localparam int CNTW = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] v_r;
  logic [ROOT_W+1:0]   rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [CNTW-1:0]     cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [ROOT_W+3:0]   rem_sh;
  logic [ROOT_W+3:0]   trial;
  logic                ge;

  // One result bit per cycle: bring down the next pair of radicand bits.
  always_comb begin
    rem_sh = {rem_r, v_r[2*ROOT_W-1 -: 2]};
    trial  = (ROOT_W+4)'({root_r, 2'b01});
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNTW'(ROOT_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        v_r    <= v_r << 2;
        rem_r  <= ge ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  assign root = (ROOT_W+1)'(root_r) +
                (ROOT_W+1)'(rem_r > (ROOT_W+2)'(root_r));
  assign done = done_r;

endmodule
`default_nettype wire

// ----- design/bezier_path_flattener_top.sv -----
// Bezier path flattener: turns path commands into a stream of polyline points.
// Input channel (in_*): one item is one command (move, line, quadratic, cubic,
// close) with its control and target points in signed Q15.8. It is taken when
// in_valid is high and in_stall is low; in_stall stays high while a command
// is being worked on, so one command is handled at a time.
// Output channel (out_*): one item per point, with the segment start flag,
// the running Q24.8 path length and a last flag on the final point of the
// command. A held output is kept stable while out_stall is high, and the
// block waits with the next point until the output register is free.
// Processing: line and close square the step from the previous point and
// take its root for the length (move emits its target without one). Curve
// points share one multiplier for the Bernstein weights, the sums and the
// squares, and bit-serial units divide by N^2 or N^3 and take the root.
// Configuration: cfg_wr_en writes the points per curve; the user must do so
// only while idle, since the block itself does not enforce it.
// Reset (synchronous, rst_n low) clears the previous point, move target and
// length, marks the segment empty and sets 16 points per curve.
`default_nettype none
module bezier_path_flattener_top #(
  parameter int MAX_EVAL_POINTS = 64,
  parameter int COORD_WIDTH     = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bpf_pkg::EVAL_W-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bpf_pkg::KIND_W-1:0]    in_kind,
  input  wire logic signed [COORD_WIDTH-1:0] in_ctrl1_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_ctrl1_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_ctrl2_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_ctrl2_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_end_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_point_x,
  output logic signed [COORD_WIDTH-1:0]      out_point_y,
  output logic                               out_segment_start,
  output logic [bpf_pkg::LEN_W-1:0]          out_total_length,
  output logic                               out_last
);

  localparam int CW   = COORD_WIDTH;
  localparam int NB   = $clog2(MAX_EVAL_POINTS + 1);
  localparam int U2W  = 2 * NB;
  localparam int WW   = 3 * NB + 2;
  localparam int MA   = (CW + 1 > U2W + 1) ? CW + 1 : U2W + 1;
  localparam int MB   = (CW + 1 > WW + 1) ? CW + 1 : WW + 1;
  localparam int PW   = MA + MB;
  localparam int AW   = CW + 3 * NB + 3;
  localparam int QW   = CW + 1;
  localparam int SCW  = $clog2(QW + 2);
  localparam int VW   = 2 * CW + 2;
  localparam int RTW  = CW + 1;
  localparam int LW   = bpf_pkg::LEN_W;
  localparam int LSW  = (LW + 1 > RTW + 2) ? LW + 1 : RTW + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WGT  = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]                state_r;
  logic [SCW-1:0]            step_r;
  logic [SCW-1:0]            dcnt_r;
  logic                      ph_r;
  logic                      cubic_r;
  logic                      curve_r;
  logic [NB-1:0]             n_r;
  logic [NB-1:0]             i_r;
  logic [bpf_pkg::EVAL_W-1:0] eval_r;

  logic signed [CW-1:0]      ax_r, ay_r, c1x_r, c1y_r, c2x_r, c2y_r, ex_r, ey_r;
  logic signed [CW-1:0]      px_r, py_r, prev_x_r, prev_y_r, mt_x_r, mt_y_r;
  logic                      seg_empty_r;
  logic [LW-1:0]             len_r;

  logic [U2W-1:0]            u2_r, i2_r;
  logic [WW-1:0]             w_r [4];
  logic signed [AW-1:0]      acc_r;
  logic                      axis_r;
  logic [AW-1:0]             rem_r, dsh_r;
  logic [QW-1:0]             q_r;
  logic                      neg_r;
  logic [VW-1:0]             dx2_r;
  logic signed [PW-1:0]      prod_r;

  logic                      out_valid_r;
  logic signed [CW-1:0]      out_x_r, out_y_r;
  logic                      out_start_r, out_last_r;
  logic [LW-1:0]             out_len_r;

  logic [NB-1:0]             n_clamp;
  logic [NB-1:0]             u;
  logic signed [MA-1:0]      mul_a;
  logic signed [MB-1:0]      mul_b;
  logic [WW-1:0]             p_w;
  logic signed [CW-1:0]      sel_c;
  logic signed [CW:0]        dx, dy;
  logic [AW-1:0]             d_aw, den, mag;
  logic signed [AW-1:0]      num;
  logic                      ge;
  logic [QW-1:0]             qn;
  logic                      sq_start, sq_done;
  logic [VW-1:0]             radicand;
  logic [RTW:0]              sq_root;
  logic [LSW-1:0]            len_sum;

  // Points per curve: zero acts as one, anything above the maximum is capped.
  always_comb begin
    if (eval_r == '0) begin
      n_clamp = NB'(1);
    end else if (int'(eval_r) > MAX_EVAL_POINTS) begin
      n_clamp = NB'(MAX_EVAL_POINTS);
    end else begin
      n_clamp = NB'(eval_r);
    end
  end

  assign u   = n_r - i_r;
  assign p_w = WW'(prod_r);
  assign dx  = (CW+1)'(px_r) - (CW+1)'(prev_x_r);
  assign dy  = (CW+1)'(py_r) - (CW+1)'(prev_y_r);

  // Coordinate for the current term of the Bernstein sum.
  always_comb begin
    case (step_r[2:0])
      3'd0:    sel_c = ax_r;
      3'd1:    sel_c = c1x_r;
      3'd2:    sel_c = c2x_r;
      3'd3:    sel_c = ex_r;
      3'd4:    sel_c = ay_r;
      3'd5:    sel_c = c1y_r;
      3'd6:    sel_c = c2y_r;
      default: sel_c = ey_r;
    endcase
  end

  // Operand selection for the shared multiplier. Weight steps build
  // u^2, i^2 and then the four weights; quadratic curves use a zero weight
  // for the second control point.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_WGT: begin
        case (step_r)
          SCW'(0): begin
            mul_a = MA'(signed'({1'b0, u}));
            mul_b = MB'(signed'({1'b0, u}));
          end
          SCW'(1): begin
            mul_a = MA'(signed'({1'b0, i_r}));
            mul_b = MB'(signed'({1'b0, i_r}));
          end
          SCW'(2): begin
            mul_a = MA'(signed'({1'b0, u2_r}));
            mul_b = cubic_r ? MB'(signed'({1'b0, u})) : MB'(1);
          end
          SCW'(3): begin
            mul_a = cubic_r ? MA'(signed'({1'b0, u2_r})) : MA'(signed'({1'b0, u}));
            mul_b = MB'(signed'({1'b0, i_r}));
          end
          SCW'(4): begin
            mul_a = cubic_r ? MA'(signed'({1'b0, u})) : '0;
            mul_b = MB'(signed'({1'b0, i2_r}));
          end
          default: begin
            mul_a = MA'(signed'({1'b0, i2_r}));
            mul_b = cubic_r ? MB'(signed'({1'b0, i_r})) : MB'(1);
          end
        endcase
      end
      S_MAC: begin
        mul_a = MA'(sel_c);
        mul_b = MB'(signed'({1'b0, w_r[step_r[1:0]]}));
      end
      S_SQ: begin
        mul_a = (step_r == '0) ? MA'(dx) : MA'(dy);
        mul_b = (step_r == '0) ? MB'(dx) : MB'(dy);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounded division setup: floor((2S + d) / 2d), where the weights sum to d.
  always_comb begin
    d_aw = AW'(w_r[0]) + AW'(w_r[1]) + AW'(w_r[2]) + AW'(w_r[3]);
    den  = d_aw << 1;
    num  = (acc_r <<< 1) + signed'(d_aw);
    mag  = num[AW-1] ? (AW'(-num) + den - AW'(1)) : AW'(num);
    ge   = (rem_r >= dsh_r);
    qn   = neg_r ? (~q_r + QW'(1)) : q_r;
  end

  assign sq_start = (state_r == S_SQ) && ph_r && !seg_empty_r && (step_r == SCW'(1));
  assign radicand = dx2_r + VW'(prod_r);
  assign len_sum  = LSW'(len_r) + LSW'(sq_root);

  bpf_isqrt #(
    .ROOT_W (RTW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      dcnt_r      <= '0;
      ph_r        <= 1'b0;
      eval_r      <= bpf_pkg::EVAL_RESET;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      mt_x_r      <= '0;
      mt_y_r      <= '0;
      seg_empty_r <= 1'b1;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        eval_r <= cfg_wr_data;
      end
      // The emit state loads the output register itself when it is free.
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          step_r <= '0;
          ph_r   <= 1'b0;
          dcnt_r <= '0;
          if (in_valid) begin
            case (in_kind) inside
              bpf_pkg::K_MOVE: begin
                px_r        <= in_end_x;
                py_r        <= in_end_y;
                mt_x_r      <= in_end_x;
                mt_y_r      <= in_end_y;
                seg_empty_r <= 1'b1;
                curve_r     <= 1'b0;
                state_r     <= S_SQ;
              end
              bpf_pkg::K_LINE: begin
                px_r    <= in_end_x;
                py_r    <= in_end_y;
                curve_r <= 1'b0;
                state_r <= S_SQ;
              end
              bpf_pkg::K_CLOSE: begin
                px_r    <= mt_x_r;
                py_r    <= mt_y_r;
                curve_r <= 1'b0;
                state_r <= S_SQ;
              end
              bpf_pkg::K_QUAD, bpf_pkg::K_CUBIC: begin
                ax_r    <= prev_x_r;
                ay_r    <= prev_y_r;
                c1x_r   <= in_ctrl1_x;
                c1y_r   <= in_ctrl1_y;
                c2x_r   <= in_ctrl2_x;
                c2y_r   <= in_ctrl2_y;
                ex_r    <= in_end_x;
                ey_r    <= in_end_y;
                n_r     <= n_clamp;
                i_r     <= NB'(1);
                cubic_r <= (in_kind == bpf_pkg::K_CUBIC);
                curve_r <= 1'b1;
                state_r <= S_WGT;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_WGT: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            case (step_r)
              SCW'(0): u2_r <= U2W'(prod_r);
              SCW'(1): i2_r <= U2W'(prod_r);
              SCW'(2): w_r[0] <= p_w;
              SCW'(3): w_r[1] <= cubic_r ? (p_w + (p_w << 1)) : (p_w << 1);
              SCW'(4): w_r[2] <= p_w + (p_w << 1);
              default: w_r[3] <= p_w;
            endcase
            if (step_r == SCW'(5)) begin
              step_r  <= '0;
              acc_r   <= '0;
              state_r <= S_MAC;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end
        S_MAC: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            acc_r  <= acc_r + AW'(prod_r);
            step_r <= step_r + 1'b1;
            if (step_r[1:0] == 2'd3) begin
              axis_r  <= step_r[2];
              dcnt_r  <= '0;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == '0) begin
            rem_r <= mag;
            dsh_r <= den << (QW - 1);
            neg_r <= num[AW-1];
            q_r   <= '0;
          end else if (dcnt_r == SCW'(QW + 1)) begin
            dcnt_r <= '0;
            acc_r  <= '0;
            if (!axis_r) begin
              px_r    <= CW'(qn);
              state_r <= S_MAC;
            end else begin
              py_r    <= CW'(qn);
              step_r  <= '0;
              state_r <= S_SQ;
            end
          end else begin
            if (ge) begin
              rem_r <= rem_r - dsh_r;
            end
            q_r   <= {q_r[QW-2:0], ge};
            dsh_r <= dsh_r >> 1;
          end
        end
        S_SQ: begin
          if (seg_empty_r) begin
            state_r <= S_EMIT;
          end else begin
            ph_r <= !ph_r;
            if (ph_r) begin
              if (step_r == '0) begin
                dx2_r  <= VW'(prod_r);
                step_r <= SCW'(1);
              end else begin
                step_r  <= '0;
                state_r <= S_ROOT;
              end
            end
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            len_r   <= (|len_sum[LSW-1:LW]) ? '1 : len_sum[LW-1:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_x_r     <= px_r;
            out_y_r     <= py_r;
            out_start_r <= seg_empty_r;
            out_len_r   <= len_r;
            out_last_r  <= !curve_r || (i_r == n_r);
            prev_x_r    <= px_r;
            prev_y_r    <= py_r;
            seg_empty_r <= 1'b0;
            ph_r        <= 1'b0;
            step_r      <= '0;
            if (curve_r && (i_r != n_r)) begin
              i_r     <= i_r + 1'b1;
              state_r <= S_WGT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_point_x       = out_x_r;
  assign out_point_y       = out_y_r;
  assign out_segment_start = out_start_r;
  assign out_total_length  = out_len_r;
  assign out_last          = out_last_r;

endmodule
`default_nettype wire
